/* sv/tfef_pkg.sv */
// shared types and constants for the triangle-free edge filter
`timescale 1ns / 1ps
package tfef_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned VIDX_W       = $clog2(MAX_VERTICES);
  localparam int unsigned DEG_W        = 6;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned VC_W         = 7;
  localparam int unsigned STATUS_W     = 3;

  localparam logic [VC_W-1:0] VC_RESET = VC_W'(64);
  localparam logic [VC_W-1:0] VC_LIMIT = VC_W'(MAX_VERTICES);

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT    = 3'd0,
    ST_TRIANGLE  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_RANGE     = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_WRB
  } state_e;

  typedef struct packed {
    logic              action;
    logic [VIDX_W-1:0] vertex_a;
    logic [VIDX_W-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DEG_W-1:0]    max_degree;
    logic [CNT_W-1:0]    edge_count;
  } rsp_t;

  typedef struct packed {
    logic [DEG_W-1:0]        degree;
    logic [MAX_VERTICES-1:0] row;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [VIDX_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [VIDX_W-1:0] rd_addr_a;
    logic [VIDX_W-1:0] rd_addr_b;
  } mem_ctrl_t;

endpackage

/* sv/tfef_adj_mem.sv */
// adjacency row and degree memory, one write port and two registered read ports
`timescale 1ns / 1ps
module tfef_adj_mem (
  input  logic                clk_i,
  input  tfef_pkg::mem_ctrl_t ctrl_i,
  output tfef_pkg::entry_t    rd_a_o,
  output tfef_pkg::entry_t    rd_b_o
);

  tfef_pkg::entry_t mem_q [tfef_pkg::MAX_VERTICES];
  tfef_pkg::entry_t rd_a_q;
  tfef_pkg::entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    rd_a_q <= mem_q[ctrl_i.rd_addr_a];
    rd_b_q <= mem_q[ctrl_i.rd_addr_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

/* sv/tfef_ctrl.sv */
// sequencer: edge checks, graph counters, row valid bits and result register
`timescale 1ns / 1ps
module tfef_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tfef_pkg::VC_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tfef_pkg::req_t                     in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tfef_pkg::rsp_t                     out_rsp_o,
  output tfef_pkg::mem_ctrl_t                mem_o,
  input  tfef_pkg::entry_t                   rd_a_i,
  input  tfef_pkg::entry_t                   rd_b_i
);

  tfef_pkg::state_e                      state_q, state_d;
  logic [tfef_pkg::VC_W-1:0]             vc_q;
  logic [tfef_pkg::MAX_VERTICES-1:0]     valid_q, valid_d;
  logic [tfef_pkg::DEG_W-1:0]            max_q, max_d;
  logic [tfef_pkg::CNT_W-1:0]            cnt_q, cnt_d;
  tfef_pkg::req_t                        req_q, req_d;
  tfef_pkg::entry_t                      wrb_q, wrb_d;
  logic                                  out_valid_q, out_valid_d;
  tfef_pkg::rsp_t                        out_q, out_d;

  logic [tfef_pkg::VC_W-1:0]             limit;
  logic [tfef_pkg::MAX_VERTICES-1:0]     row_a, row_b;
  logic [tfef_pkg::DEG_W-1:0]            deg_a, deg_b, inc_a, inc_b, max_ab;
  logic                                  out_busy, bad_range, dup, closes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfef_pkg::S_IDLE;
      vc_q        <= tfef_pkg::VC_RESET;
      valid_q     <= '0;
      max_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      max_q       <= max_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    wrb_q <= wrb_d;
    out_q <= out_d;
  end

  // invalid rows read as empty with degree zero
  assign row_a = valid_q[req_q.vertex_a] ? rd_a_i.row : '0;
  assign row_b = valid_q[req_q.vertex_b] ? rd_b_i.row : '0;
  assign deg_a = valid_q[req_q.vertex_a] ? rd_a_i.degree : '0;
  assign deg_b = valid_q[req_q.vertex_b] ? rd_b_i.degree : '0;
  assign inc_a = deg_a + tfef_pkg::DEG_W'(1);
  assign inc_b = deg_b + tfef_pkg::DEG_W'(1);
  assign max_ab = (inc_a > inc_b) ? inc_a : inc_b;

  assign limit     = (vc_q > tfef_pkg::VC_LIMIT) ? tfef_pkg::VC_LIMIT : vc_q;
  assign bad_range = ({1'b0, req_q.vertex_a} >= limit) || ({1'b0, req_q.vertex_b} >= limit);
  assign dup       = (req_q.vertex_a == req_q.vertex_b) || row_a[req_q.vertex_b];
  assign closes    = |(row_a & row_b);
  assign out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    max_d       = max_q;
    cnt_d       = cnt_q;
    req_d       = req_q;
    wrb_d       = wrb_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    mem_o.we        = 1'b0;
    mem_o.wr_addr   = req_q.vertex_a;
    mem_o.wr_data   = '{degree: inc_a,
                        row: row_a | (tfef_pkg::MAX_VERTICES'(1) << req_q.vertex_b)};
    mem_o.rd_addr_a = req_q.vertex_a;
    mem_o.rd_addr_b = req_q.vertex_b;

    unique case (state_q)
      tfef_pkg::S_IDLE: begin
        in_ready_o      = 1'b1;
        mem_o.rd_addr_a = in_req_i.vertex_a;
        mem_o.rd_addr_b = in_req_i.vertex_b;
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = tfef_pkg::S_EVAL;
        end
      end
      tfef_pkg::S_EVAL: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          state_d     = tfef_pkg::S_IDLE;
          if (req_q.action == tfef_pkg::ACT_CLEAR) begin
            valid_d = '0;
            max_d   = '0;
            cnt_d   = '0;
            out_d   = '{status: tfef_pkg::ST_CLEARED, max_degree: '0, edge_count: '0};
          end else if (bad_range) begin
            out_d = '{status: tfef_pkg::ST_RANGE, max_degree: max_q, edge_count: cnt_q};
          end else if (dup) begin
            out_d = '{status: tfef_pkg::ST_DUPLICATE, max_degree: max_q, edge_count: cnt_q};
          end else if (closes) begin
            out_d = '{status: tfef_pkg::ST_TRIANGLE, max_degree: max_q, edge_count: cnt_q};
          end else begin
            mem_o.we = 1'b1;
            valid_d[req_q.vertex_a] = 1'b1;
            valid_d[req_q.vertex_b] = 1'b1;
            max_d   = (max_ab > max_q) ? max_ab : max_q;
            cnt_d   = cnt_q + tfef_pkg::CNT_W'(1);
            wrb_d   = '{degree: inc_b,
                        row: row_b | (tfef_pkg::MAX_VERTICES'(1) << req_q.vertex_a)};
            out_d   = '{status: tfef_pkg::ST_ACCEPT, max_degree: max_d, edge_count: cnt_d};
            state_d = tfef_pkg::S_WRB;
          end
        end
      end
      tfef_pkg::S_WRB: begin
        mem_o.we      = 1'b1;
        mem_o.wr_addr = req_q.vertex_b;
        mem_o.wr_data = wrb_q;
        state_d       = tfef_pkg::S_IDLE;
      end
      default: begin
        state_d = tfef_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* sv/triangle_free_edge_filter_top.sv */
// top level of the triangle-free edge filter
//   channel   direction  handshake              payload
//   in        request    in_valid_i/in_ready_o  in_req_i (action, vertex_a, vertex_b)
//   out       result     out_valid_o/out_ready_i out_rsp_o (status, max_degree, edge_count)
//   cfg       write      cfg_we_i               cfg_wdata_i (vertex_count)
// a rejected edge or a clear passes through evaluation only, an accepted edge
// also through a write-back state: the two adjacency rows are read together,
// then written back one per cycle through the single write port of the row memory
// reset clears the row valid bits, counters and result valid flag, not the result payload
// a request waits in evaluation while the previous result is not yet taken
`timescale 1ns / 1ps
module triangle_free_edge_filter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tfef_pkg::VC_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tfef_pkg::req_t             in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tfef_pkg::rsp_t             out_rsp_o
);

  tfef_pkg::mem_ctrl_t mem_ctrl;
  tfef_pkg::entry_t    rd_a;
  tfef_pkg::entry_t    rd_b;

  tfef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .mem_o       (mem_ctrl),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b)
  );

  tfef_adj_mem u_mem (
    .clk_i  (clk_i),
    .ctrl_i (mem_ctrl),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

endmodule
